FILE: rtl/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Command and status codes shared by the sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int CmdW    = 2;
  localparam int StatusW = 3;
  localparam int ValueW  = 32;
  localparam int CountW  = 5;

  typedef logic [CmdW-1:0]    cmd_t;
  typedef logic [StatusW-1:0] status_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_DELETE = 2'd1;
  localparam cmd_t CMD_SEARCH = 2'd2;

  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_DELETED   = 3'd1;
  localparam status_t ST_FOUND     = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_EMPTY     = 3'd4;
  localparam status_t ST_FULL      = 3'd5;

endpackage

FILE: rtl/slt_ram.sv
// ----------------------------------------------------------------------------
// slt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sorted_list_table_core.sv
// ----------------------------------------------------------------------------
// sorted_list_table_core
// Bounded store of signed values kept in ascending order in a RAM.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry a beat of in_cmd (insert, delete,
// search) and in_value. Result channel: out_valid/out_stall carry a beat of
// out_status and out_entry_count (entry count after the command, low 5 bits).
// One command is worked at a time; in_stall is high while it runs.
// Insert walks from the tail toward its slot, moving each larger entry up
// one place, and writes the value where the walk stops (at the head when
// every stored entry is greater than the value).
// Delete and search walk from the head, one RAM read and compare per entry;
// delete moves the entries after the match down as it goes and walks all
// stored entries, while search stops at the first match.
// Full insert, empty delete/search and unused codes go straight to the done state.
// Each step is bounded by the single RAM read port with registered read data.
// The result sits in an output register; a stalled result holds the
// finished command, and the next command is accepted as soon as the result
// has been loaded into that register.
// Reset empties the store at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_list_table_core #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [slt_pkg::CmdW-1:0]   in_cmd,
  input  logic signed [31:0]         in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [slt_pkg::StatusW-1:0] out_status,
  output logic [slt_pkg::CountW-1:0] out_entry_count
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > slt_pkg::CountW) ? CW : slt_pkg::CountW;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_CMP  = 3'd2;
  localparam logic [2:0] S_SCAN_RD  = 3'd3;
  localparam logic [2:0] S_SCAN_CMP = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic                    found_r, found_nxt;
  slt_pkg::cmd_t           cmd_r, cmd_nxt;
  logic signed [31:0]      val_r, val_nxt;
  slt_pkg::status_t        st_r, st_nxt;
  logic                    out_valid_r, out_valid_nxt;
  slt_pkg::status_t        out_status_r, out_status_nxt;
  logic [slt_pkg::CountW-1:0] out_cnt_r, out_cnt_nxt;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [31:0]             ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [31:0]             ram_rdata;
  logic [CW-1:0]           idx_m1;
  logic [EW-1:0]           cnt_ext;

  slt_ram #(
    .WIDTH (slt_pkg::ValueW),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign idx_m1          = idx_r - CW'(1);
  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_cnt_r;
  assign cnt_ext         = EW'(count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[AW-1:0];
    ram_wdata      = val_r;
    ram_raddr      = idx_r[AW-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          val_nxt   = in_value;
          found_nxt = 1'b0;
          state_nxt = S_DONE;
          case (in_cmd)
            slt_pkg::CMD_INSERT: begin
              if (count_r == CW'(MAX_ENTRIES)) begin
                st_nxt = slt_pkg::ST_FULL;
              end else begin
                idx_nxt   = count_r;
                state_nxt = S_INS_RD;
              end
            end
            slt_pkg::CMD_DELETE: begin
              if (count_r == '0) begin
                st_nxt = slt_pkg::ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SCAN_RD;
              end
            end
            slt_pkg::CMD_SEARCH: begin
              if (count_r == '0) begin
                st_nxt = slt_pkg::ST_NOT_FOUND;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SCAN_RD;
              end
            end
            default: begin
              st_nxt = slt_pkg::ST_NOT_FOUND;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (idx_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = val_r;
          count_nxt = count_r + CW'(1);
          st_nxt    = slt_pkg::ST_INSERTED;
          state_nxt = S_DONE;
        end else begin
          ram_raddr = idx_m1[AW-1:0];
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        if ($signed(ram_rdata) > val_r) begin
          ram_wdata = ram_rdata;
          idx_nxt   = idx_m1;
          state_nxt = S_INS_RD;
        end else begin
          ram_wdata = val_r;
          count_nxt = count_r + CW'(1);
          st_nxt    = slt_pkg::ST_INSERTED;
          state_nxt = S_DONE;
        end
      end
      S_SCAN_RD: begin
        if (idx_r == count_r) begin
          state_nxt = S_DONE;
          if (found_r) begin
            count_nxt = count_r - CW'(1);
            st_nxt    = slt_pkg::ST_DELETED;
          end else begin
            st_nxt    = slt_pkg::ST_NOT_FOUND;
          end
        end else begin
          ram_raddr = idx_r[AW-1:0];
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_SCAN_RD;
        if (found_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_m1[AW-1:0];
          ram_wdata = ram_rdata;
        end else if (ram_rdata == val_r) begin
          if (cmd_r == slt_pkg::CMD_SEARCH) begin
            st_nxt    = slt_pkg::ST_FOUND;
            state_nxt = S_DONE;
          end else begin
            found_nxt = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_cnt_nxt    = cnt_ext[slt_pkg::CountW-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    st_r         <= st_nxt;
    out_status_r <= out_status_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_list_table_core.
// ----------------------------------------------------------------------------
// Commands are queued up front, then driven on the falling edge with random
// gaps. A queue-based copy of the ascending store predicts the status and
// the entry count of every accepted beat. Each result beat is checked
// against the oldest prediction. The receiver stalls at random, holds off
// once for a long stretch so the block backs up, and runs gap-free for a
// while. A watchdog ends the run if traffic stops.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxEntries  = 16;
  localparam int QuietLimit  = 4000;
  localparam int HoldCycles  = 300;
  localparam int HoldAtBeat  = 300;
  localparam int DrainCycles = 60;

  typedef logic [slt_pkg::CountW-1:0] count_t;

  typedef struct {
    slt_pkg::cmd_t      cmd;
    logic signed [31:0] value;
  } cmd_beat_t;

  typedef struct {
    slt_pkg::status_t status;
    count_t           count;
  } result_beat_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [slt_pkg::CmdW-1:0]      in_cmd;
  logic signed [31:0]            in_value;
  logic                          out_valid;
  logic                          out_stall;
  logic [slt_pkg::StatusW-1:0]   out_status;
  logic [slt_pkg::CountW-1:0]    out_entry_count;

  cmd_beat_t            cmd_queue[$];
  result_beat_t         expected_results[$];
  logic signed [31:0]   shelf[$];          // predicted store contents
  logic signed [31:0]   value_pool[8];
  logic signed [31:0]   recent_inserts[$];

  bit in_taken;
  int beats_in;
  int total_beats;
  int error_count;
  int hold_left;
  bit hold_done;
  int quiet_cycles;

  wire calm = beats_in >= 550 && beats_in < 700;

  sorted_list_table_core #(.MAX_ENTRIES(MaxEntries)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_entry_count(out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Update the predicted store and return the status of one command.
  function automatic slt_pkg::status_t apply_command(slt_pkg::cmd_t cmd,
                                                     logic signed [31:0] v);
    int pos;
    int hit;
    slt_pkg::status_t st;
    hit = -1;
    for (int i = 0; i < shelf.size(); i++) begin
      if (hit < 0 && shelf[i] == v) hit = i;
    end
    case (cmd)
      slt_pkg::CMD_INSERT: begin
        if (shelf.size() >= MaxEntries) begin
          st = slt_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < shelf.size() && shelf[pos] <= v) pos++;
          shelf.insert(pos, v);
          st = slt_pkg::ST_INSERTED;
        end
      end
      slt_pkg::CMD_DELETE: begin
        if (shelf.size() == 0) begin
          st = slt_pkg::ST_EMPTY;
        end else if (hit < 0) begin
          st = slt_pkg::ST_NOT_FOUND;
        end else begin
          shelf.delete(hit);
          st = slt_pkg::ST_DELETED;
        end
      end
      slt_pkg::CMD_SEARCH: st = (hit >= 0) ? slt_pkg::ST_FOUND : slt_pkg::ST_NOT_FOUND;
      default:             st = slt_pkg::ST_NOT_FOUND;
    endcase
    return st;
  endfunction

  task automatic queue_cmd(slt_pkg::cmd_t cmd, logic signed [31:0] v);
    cmd_beat_t b;
    b.cmd = cmd;
    b.value = v;
    cmd_queue.push_back(b);
    if (cmd == slt_pkg::CMD_INSERT) begin
      recent_inserts.push_back(v);
      if (recent_inserts.size() > 32) void'(recent_inserts.pop_front());
    end
  endtask

  function automatic logic signed [31:0] lookup_value();
    int r;
    r = $urandom_range(9);
    if (r < 4) return value_pool[$urandom_range(7)];
    if (r < 8 && recent_inserts.size() > 0)
      return recent_inserts[$urandom_range(recent_inserts.size() - 1)];
    return $urandom;
  endfunction

  function automatic logic signed [31:0] insert_value();
    if ($urandom_range(9) < 6) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // Stimulus and end of run
  initial begin
    int r;
    slt_pkg::cmd_t c;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_cmd    = slt_pkg::CMD_INSERT;
    in_value  = '0;
    out_stall = 1'b0;

    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

    // directed: empty store, unused code, extremes, duplicates, misses
    queue_cmd(slt_pkg::CMD_SEARCH, 32'sd5);
    queue_cmd(slt_pkg::CMD_DELETE, 32'sd5);
    queue_cmd(slt_pkg::cmd_t'(3), 32'sh7fff_ffff);
    queue_cmd(slt_pkg::CMD_INSERT, 32'sh7fff_ffff);
    queue_cmd(slt_pkg::CMD_INSERT, 32'sh8000_0000);
    queue_cmd(slt_pkg::CMD_INSERT, 32'sd0);
    queue_cmd(slt_pkg::CMD_INSERT, -32'sd1);
    queue_cmd(slt_pkg::CMD_INSERT, 32'sd0);
    queue_cmd(slt_pkg::CMD_SEARCH, 32'sd0);
    queue_cmd(slt_pkg::CMD_SEARCH, 32'sd7);
    queue_cmd(slt_pkg::CMD_DELETE, -32'sd1);
    queue_cmd(slt_pkg::CMD_DELETE, 32'sd7);
    queue_cmd(slt_pkg::CMD_SEARCH, 32'sh8000_0000);
    queue_cmd(slt_pkg::CMD_DELETE, 32'sh8000_0000);
    queue_cmd(slt_pkg::CMD_DELETE, 32'sh7fff_ffff);
    queue_cmd(slt_pkg::CMD_DELETE, 32'sd0);
    queue_cmd(slt_pkg::CMD_DELETE, 32'sd0);
    queue_cmd(slt_pkg::CMD_DELETE, 32'sd0);
    queue_cmd(slt_pkg::CMD_SEARCH, 32'sh7fff_ffff);

    // random: alternate fill-heavy and drain-heavy blocks
    for (int blk = 0; blk < 17; blk++) begin
      for (int k = 0; k < 50; k++) begin
        r = $urandom_range(99);
        if (blk % 2 == 0)
          c = (r < 65) ? slt_pkg::CMD_INSERT : (r < 80) ? slt_pkg::CMD_DELETE :
              (r < 95) ? slt_pkg::CMD_SEARCH : slt_pkg::cmd_t'(3);
        else
          c = (r < 20) ? slt_pkg::CMD_INSERT : (r < 70) ? slt_pkg::CMD_DELETE :
              (r < 95) ? slt_pkg::CMD_SEARCH : slt_pkg::cmd_t'(3);
        queue_cmd(c, (c == slt_pkg::CMD_INSERT) ? insert_value() : lookup_value());
      end
    end
    total_beats = cmd_queue.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (beats_in < total_beats || expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Sender
  always @(negedge clk) begin : drive_in
    cmd_beat_t nb;
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (cmd_queue.size() > 0 && (calm || $urandom_range(99) >= 26)) begin
          nb = cmd_queue.pop_front();
          in_valid <= 1'b1;
          in_cmd   <= nb.cmd;
          in_value <= nb.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver, with one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && beats_in >= HoldAtBeat) begin
        out_stall <= 1'b1;
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 26);
      end
    end
  end

  // Beat monitor and checker
  always @(posedge clk) begin : monitor
    result_beat_t rb;
    if (rst_n) begin
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        rb.status = apply_command(slt_pkg::cmd_t'(in_cmd), in_value);
        rb.count  = count_t'(shelf.size());
        expected_results.push_back(rb);
        beats_in++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: status %0d count %0d",
                 out_status, out_entry_count);
          error_count++;
        end else begin
          rb = expected_results.pop_front();
          if (out_status !== rb.status) begin
            $error("status mismatch: expected %0d actual %0d", rb.status, out_status);
            error_count++;
          end
          if (out_entry_count !== rb.count) begin
            $error("entry_count mismatch: expected %0d actual %0d",
                   rb.count, out_entry_count);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

FILE: sorted_list_table_core.f
rtl/slt_pkg.sv
rtl/slt_ram.sv
rtl/sorted_list_table_core.sv
tb/tb_top.sv
